[src/qwvp_pkg.sv]
package qwvp_pkg;

	// Block dimensions
	localparam int WHEELS        = 4;
	localparam int HIST_DEPTH    = 8;
	localparam int WIN_LEN       = 8;
	localparam int WIN_LOG       = 3;
	localparam int SETPOINT_REGS = 4;

	localparam int WHEEL_W    = (WHEELS > 1) ? $clog2(WHEELS) : 1;
	localparam int SLOT_W     = $clog2(HIST_DEPTH);
	localparam int RING_DEPTH = WHEELS * HIST_DEPTH;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int WIN_W      = $clog2(WIN_LEN);
	localparam int SP_W       = (SETPOINT_REGS > 1) ? $clog2(SETPOINT_REGS) : 1;
	// newest minus oldest needs 17 bits; the window shift drops WIN_LOG of them
	localparam int DIF_W      = 17 - WIN_LOG;

	// Register file
	localparam int REG_IDX_W = 3;
	localparam int APB_AW    = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV = 3'd6;

	localparam logic signed [31:0] GAIN_PROP_RST  = 32'sd7864320;
	localparam logic signed [31:0] GAIN_INTEG_RST = 32'sd0;
	localparam logic signed [31:0] GAIN_DERIV_RST = 32'sd2621;

	// Request kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_ENCODER = 2'd0;
	localparam kind_t KIND_SAMPLE  = 2'd1;
	localparam kind_t KIND_COMPUTE = 2'd2;

	typedef struct packed {
		logic [SETPOINT_REGS-1:0][15:0] setpoint;
		logic signed [31:0]             gain_prop;
		logic signed [31:0]             gain_integ;
		logic signed [31:0]             gain_deriv;
	} cfg_t;

	// One word of per-wheel state
	typedef struct packed {
		logic [1:0]        prev;
		logic [15:0]       tick;
		logic [15:0]       last;
		logic [SLOT_W-1:0] head;
	} whl_t;

	typedef struct packed {
		logic                    start;
		logic signed [15:0]      newest;
		logic [15:0]             isum;
		logic signed [DIF_W-1:0] dif;
	} mac_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] value;
		logic               sat;
	} mac_res_t;

	// Flat address of one slot of one wheel's error ring
	function automatic logic [RING_AW-1:0] ring_addr(input logic [WHEEL_W-1:0] w,
			input logic [SLOT_W-1:0] s);
		return RING_AW'(RING_AW'(w) * RING_AW'(HIST_DEPTH)) + RING_AW'(s);
	endfunction

endpackage

[src/qwvp_ram.sv]
module qwvp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/qwvp_cfg.sv]
module qwvp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qwvp_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output qwvp_pkg::cfg_t               cfg
);

	logic [qwvp_pkg::SETPOINT_REGS-1:0][15:0] setpoint_q;
	logic signed [31:0]                       gain_prop_q;
	logic signed [31:0]                       gain_integ_q;
	logic signed [31:0]                       gain_deriv_q;
	logic [qwvp_pkg::REG_IDX_W-1:0]           idx;
	logic                                     wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[qwvp_pkg::APB_AW-1:2];
	assign wr_en  = psel & penable & pwrite & pready;

	// Take register writes; unknown indexes drop the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= '0;
			gain_prop_q  <= qwvp_pkg::GAIN_PROP_RST;
			gain_integ_q <= qwvp_pkg::GAIN_INTEG_RST;
			gain_deriv_q <= qwvp_pkg::GAIN_DERIV_RST;
		end else if (wr_en) begin
			priority if (32'(idx) < qwvp_pkg::SETPOINT_REGS) begin
				setpoint_q[qwvp_pkg::SP_W'(idx)] <= pwdata[15:0];
			end else if (idx == qwvp_pkg::REG_GAIN_PROP) begin
				gain_prop_q <= pwdata;
			end else if (idx == qwvp_pkg::REG_GAIN_INTEG) begin
				gain_integ_q <= pwdata;
			end else if (idx == qwvp_pkg::REG_GAIN_DERIV) begin
				gain_deriv_q <= pwdata;
			end else begin
				gain_prop_q <= gain_prop_q;
			end
		end
	end

	// Read back
	always_comb begin
		priority if (32'(idx) < qwvp_pkg::SETPOINT_REGS) begin
			prdata = {16'h0000, setpoint_q[qwvp_pkg::SP_W'(idx)]};
		end else if (idx == qwvp_pkg::REG_GAIN_PROP) begin
			prdata = gain_prop_q;
		end else if (idx == qwvp_pkg::REG_GAIN_INTEG) begin
			prdata = gain_integ_q;
		end else if (idx == qwvp_pkg::REG_GAIN_DERIV) begin
			prdata = gain_deriv_q;
		end else begin
			prdata = '0;
		end
	end

	assign cfg.setpoint   = setpoint_q;
	assign cfg.gain_prop  = gain_prop_q;
	assign cfg.gain_integ = gain_integ_q;
	assign cfg.gain_deriv = gain_deriv_q;

endmodule

[src/qwvp_mac.sv]
module qwvp_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  qwvp_pkg::cfg_t      cfg,
	input  qwvp_pkg::mac_req_t  req,
	output qwvp_pkg::mac_res_t  res
);

	localparam int PROD_W = 49;
	localparam int SH_W   = PROD_W - 16;
	localparam int ACC_W  = SH_W + 2;

	localparam logic [2:0] MPH_PROP  = 3'd0;
	localparam logic [2:0] MPH_INTEG = 3'd1;
	localparam logic [2:0] MPH_DERIV = 3'd2;
	localparam logic [2:0] MPH_LAST  = 3'd3;
	localparam logic [2:0] MPH_SAT   = 3'd4;

	logic                                busy_q;
	logic [2:0]                          ph_q;
	logic                                done_q;
	logic signed [15:0]                  newest_q;
	logic signed [15:0]                  isum_q;
	logic signed [qwvp_pkg::DIF_W-1:0]   dif_q;
	logic signed [PROD_W-1:0]            prod_q;
	logic signed [ACC_W-1:0]             acc_q;
	logic signed [15:0]                  value_q;
	logic                                sat_q;

	logic signed [31:0]       mul_a;
	logic signed [16:0]       mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [SH_W-1:0]   prod_sh;
	logic signed [ACC_W-1:0]  acc_nxt;

	// Pick the gain and operand of the current term
	always_comb begin
		unique case (ph_q)
			MPH_PROP: begin
				mul_a = cfg.gain_prop;
				mul_b = 17'(newest_q);
			end
			MPH_INTEG: begin
				mul_a = cfg.gain_integ;
				mul_b = 17'(isum_q);
			end
			default: begin
				mul_a = cfg.gain_deriv;
				mul_b = 17'(dif_q);
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	// Drop the fraction bits, flooring toward minus infinity
	assign prod_sh = prod_q[PROD_W-1:16];
	assign acc_nxt = acc_q + ACC_W'(prod_sh);

	// Phase sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= MPH_PROP;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !req.start && (ph_q == MPH_SAT);
			if (req.start) begin
				busy_q <= 1'b1;
				ph_q   <= MPH_PROP;
			end else if (busy_q) begin
				if (ph_q == MPH_SAT) begin
					busy_q <= 1'b0;
				end
				ph_q <= ph_q + 3'd1;
			end
		end
	end

	// Multiply, accumulate and clip
	always_ff @(posedge clk) begin
		if (req.start) begin
			newest_q <= req.newest;
			isum_q   <= req.isum;
			dif_q    <= req.dif;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (ph_q == MPH_PROP || ph_q == MPH_INTEG || ph_q == MPH_DERIV) begin
				prod_q <= mul_p;
			end
			if (ph_q == MPH_INTEG || ph_q == MPH_DERIV || ph_q == MPH_LAST) begin
				acc_q <= acc_nxt;
			end
			if (ph_q == MPH_SAT) begin
				priority if (acc_q > ACC_W'(32767)) begin
					value_q <= 16'sh7FFF;
					sat_q   <= 1'b1;
				end else if (acc_q < -ACC_W'(32768)) begin
					value_q <= 16'sh8000;
					sat_q   <= 1'b1;
				end else begin
					value_q <= acc_q[15:0];
					sat_q   <= 1'b0;
				end
			end
		end
	end

	assign res.done  = done_q;
	assign res.value = value_q;
	assign res.sat   = sat_q;

endmodule

[src/quad_wheel_velocity_pid.sv]
// Channel   Fields (low bit up)                                        Handshake
// s_axis    tuser: kind[1:0]; tdata: wheel[1:0], encoder_phase[3:2]      tvalid/tready
// m_axis    tuser: drive_saturated[0]; tdata: drive_wheel[1:0],          tvalid/tready
//           drive_value[17:2]
// apb       psel/penable/pwrite/paddr/pwdata/prdata/pready, regs at 4*i  pready tied high
//
// One request at a time. Encoder event: state read, then write back.
// Sample tick: one state read and one ring write per wheel.
// Compute request: its length is set by one ring read per window slot
// and the shared multiplier taking three products in turn.
// Reset clears state and ring through valid bits; no clearing pass is needed.
// A stalled result waits in the output register; the FSM holds until it is free.
module quad_wheel_velocity_pid (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,   // wheel[1:0], encoder_phase[3:2]
	input  logic [1:0]                   s_axis_tuser,   // kind[1:0]
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [23:0]                  m_axis_tdata,   // drive_wheel[1:0], drive_value[17:2]
	output logic [0:0]                   m_axis_tuser,   // drive_saturated[0]
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qwvp_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ENC      = 3'd1;
	localparam logic [2:0] S_SMP      = 3'd2;
	localparam logic [2:0] S_CMP_HEAD = 3'd3;
	localparam logic [2:0] S_CMP_RING = 3'd4;
	localparam logic [2:0] S_CMP_DIF  = 3'd5;
	localparam logic [2:0] S_CMP_MAC  = 3'd6;
	localparam logic [2:0] S_OUT      = 3'd7;

	localparam int WW = qwvp_pkg::WHEEL_W;
	localparam int SW = qwvp_pkg::SLOT_W;
	localparam int RA = qwvp_pkg::RING_AW;

	qwvp_pkg::cfg_t     cfg;
	qwvp_pkg::mac_req_t mac_req;
	qwvp_pkg::mac_res_t mac_res;

	logic [2:0]                     state_q;
	logic [WW-1:0]                  wheel_q;
	logic [WW-1:0]                  wheel_d;
	logic [1:0]                     phase_q;
	logic [SW-1:0]                  slot_q;
	logic [qwvp_pkg::WIN_W-1:0]     k_q;
	logic [15:0]                    sum_q;
	logic [15:0]                    newest_q;
	logic [15:0]                    oldest_q;
	logic [RA-1:0]                  ring_raddr_q;
	logic [qwvp_pkg::WHEELS-1:0]    st_vld_q;
	logic [qwvp_pkg::RING_DEPTH-1:0] ring_vld_q;
	logic                           out_vld_q;
	logic [1:0]                     out_wheel_q;
	logic [15:0]                    out_value_q;
	logic                           out_sat_q;

	logic                           in_fire;
	qwvp_pkg::kind_t                in_kind;
	logic [1:0]                     in_wheel;
	logic [1:0]                     in_phase;
	logic                           wheel_ok;

	logic                           st_we;
	qwvp_pkg::whl_t                 st_wdata;
	logic [$bits(qwvp_pkg::whl_t)-1:0] st_rdata;
	qwvp_pkg::whl_t                 whl_rd;

	logic                           ring_we;
	logic [RA-1:0]                  ring_waddr;
	logic [RA-1:0]                  ring_raddr;
	logic [15:0]                    ring_rdata;
	logic [15:0]                    ring_rd;

	logic [1:0]                     pos;
	logic signed [3:0]              raw_step;
	logic signed [3:0]              step;
	logic [15:0]                    sp;
	logic [15:0]                    delta;
	logic [15:0]                    err;
	logic [SW-1:0]                  head_nxt;
	logic [SW-1:0]                  slot_dec;
	logic signed [16:0]             diff;
	logic                           out_free;

	qwvp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Per-wheel state: position, counters, ring head
	qwvp_ram #(
		.WIDTH ($bits(qwvp_pkg::whl_t)),
		.DEPTH (qwvp_pkg::WHEELS)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (wheel_q),
		.wdata (st_wdata),
		.raddr (wheel_d),
		.rdata (st_rdata)
	);

	// Error rings of all wheels
	qwvp_ram #(
		.WIDTH (16),
		.DEPTH (qwvp_pkg::RING_DEPTH)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (err),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	qwvp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (mac_req),
		.res    (mac_res)
	);

	assign in_kind       = s_axis_tuser;
	assign in_wheel      = s_axis_tdata[1:0];
	assign in_phase      = s_axis_tdata[3:2];
	assign wheel_ok      = 32'(in_wheel) < qwvp_pkg::WHEELS;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;

	// Entries never written read as their reset values
	always_comb begin
		if (st_vld_q[wheel_q]) begin
			whl_rd = st_rdata;
		end else begin
			whl_rd.prev = 2'b00;
			whl_rd.tick = 16'h0000;
			whl_rd.last = 16'h0000;
			whl_rd.head = SW'(qwvp_pkg::HIST_DEPTH - 1);
		end
	end

	assign ring_rd = ring_vld_q[ring_raddr_q] ? ring_rdata : 16'h0000;

	// Next wheel; the state memory is read at it so data lines up with wheel_q
	always_comb begin
		wheel_d = wheel_q;
		if (state_q == S_IDLE && in_fire) begin
			wheel_d = (in_kind == qwvp_pkg::KIND_SAMPLE) ? '0 : WW'(in_wheel);
		end else if (state_q == S_SMP) begin
			wheel_d = wheel_q + 1'b1;
		end
	end

	// Quadrature decode and step wrap
	assign pos      = {phase_q[1], phase_q[1] ^ phase_q[0]};
	assign raw_step = $signed({2'b00, pos}) - $signed({2'b00, whl_rd.prev});
	always_comb begin
		priority if (raw_step > 4'sd2) begin
			step = raw_step - 4'sd4;
		end else if (raw_step < -4'sd2) begin
			step = raw_step + 4'sd4;
		end else begin
			step = raw_step;
		end
	end

	// Sample error and ring advance
	assign sp       = (32'(wheel_q) < qwvp_pkg::SETPOINT_REGS) ?
			cfg.setpoint[qwvp_pkg::SP_W'(wheel_q)] : 16'h0000;
	assign delta    = whl_rd.tick - whl_rd.last;
	assign err      = sp - delta;
	assign head_nxt = (whl_rd.head == SW'(qwvp_pkg::HIST_DEPTH - 1)) ? '0 : whl_rd.head + 1'b1;
	assign slot_dec = (slot_q == '0) ? SW'(qwvp_pkg::HIST_DEPTH - 1) : slot_q - 1'b1;

	// State write-back
	always_comb begin
		st_we    = 1'b0;
		st_wdata = whl_rd;
		if (state_q == S_ENC) begin
			st_we         = 1'b1;
			st_wdata.prev = pos;
			st_wdata.tick = whl_rd.tick + 16'(step);
		end else if (state_q == S_SMP) begin
			st_we         = 1'b1;
			st_wdata.last = whl_rd.tick;
			st_wdata.head = head_nxt;
		end
	end

	assign ring_we    = (state_q == S_SMP);
	assign ring_waddr = qwvp_pkg::ring_addr(wheel_q, head_nxt);

	// Walk the ring from the newest slot backwards
	always_comb begin
		unique case (state_q)
			S_CMP_HEAD: ring_raddr = qwvp_pkg::ring_addr(wheel_q, whl_rd.head);
			S_CMP_RING: ring_raddr = qwvp_pkg::ring_addr(wheel_q, slot_dec);
			default:    ring_raddr = qwvp_pkg::ring_addr(wheel_q, slot_q);
		endcase
	end

	assign diff           = $signed({newest_q[15], newest_q}) - $signed({oldest_q[15], oldest_q});
	assign mac_req.start  = (state_q == S_CMP_DIF);
	assign mac_req.newest = newest_q;
	assign mac_req.isum   = sum_q;
	assign mac_req.dif    = diff[16:qwvp_pkg::WIN_LOG];

	// Control: sequencer, valid bits, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			st_vld_q   <= '0;
			ring_vld_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (st_we) begin
				st_vld_q[wheel_q] <= 1'b1;
			end
			if (ring_we) begin
				ring_vld_q[ring_waddr] <= 1'b1;
			end
			// Raise the result once the register frees, drop it when taken
			if (state_q == S_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_kind == qwvp_pkg::KIND_SAMPLE) begin
							state_q <= S_SMP;
						end else if (in_kind == qwvp_pkg::KIND_ENCODER && wheel_ok) begin
							state_q <= S_ENC;
						end else if (in_kind == qwvp_pkg::KIND_COMPUTE && wheel_ok) begin
							state_q <= S_CMP_HEAD;
						end
					end
				end
				S_ENC: state_q <= S_IDLE;
				S_SMP: begin
					if (32'(wheel_q) == qwvp_pkg::WHEELS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_CMP_HEAD: state_q <= S_CMP_RING;
				S_CMP_RING: begin
					if (k_q == qwvp_pkg::WIN_W'(qwvp_pkg::WIN_LEN - 1)) begin
						state_q <= S_CMP_DIF;
					end
				end
				S_CMP_DIF: state_q <= S_CMP_MAC;
				S_CMP_MAC: begin
					if (mac_res.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		wheel_q      <= wheel_d;
		ring_raddr_q <= ring_raddr;
		if (state_q == S_IDLE && in_fire) begin
			phase_q <= in_phase;
		end
		if (state_q == S_CMP_HEAD) begin
			slot_q <= whl_rd.head;
			k_q    <= '0;
			sum_q  <= '0;
		end
		if (state_q == S_CMP_RING) begin
			sum_q  <= sum_q + ring_rd;
			slot_q <= slot_dec;
			k_q    <= k_q + 1'b1;
			if (k_q == '0) begin
				newest_q <= ring_rd;
			end
			if (k_q == qwvp_pkg::WIN_W'(qwvp_pkg::WIN_LEN - 1)) begin
				oldest_q <= ring_rd;
			end
		end
		if (state_q == S_OUT && out_free) begin
			out_wheel_q <= 2'(wheel_q);
			out_value_q <= mac_res.value;
			out_sat_q   <= mac_res.sat;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'b000000, out_value_q, out_wheel_q};
	assign m_axis_tuser  = out_sat_q;

	// A result appears only after the sequencer has passed it out
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
			$rose(m_axis_tvalid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the output step");

	// The multiplier finishes only while the sequencer waits for it
	a_mac_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
			mac_res.done |-> state_q == S_CMP_MAC)
		else $error("multiplier finished with no waiting request");

	// The ring walk always starts from the head lookup
	a_ring_walk: assert property (@(posedge clk) disable iff (!arst_n)
			state_q == S_CMP_RING |-> $past(state_q) == S_CMP_HEAD ||
				$past(state_q) == S_CMP_RING)
		else $error("ring walk entered without head lookup");

endmodule
